FILE: rtl/core/display_link_failure_watchdog_assert.svh
// assertion macros for the display link failure watchdog
`ifndef DISPLAY_LINK_FAILURE_WATCHDOG_ASSERT_SVH
`define DISPLAY_LINK_FAILURE_WATCHDOG_ASSERT_SVH
`ifndef SYNTHESIS
`define DLFW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("watchdog check failed");
`define DLFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("watchdog check failed");
`else
`define DLFW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLFW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/dlfw_pkg.sv
// types and constants of the display link failure watchdog
`default_nettype none
package dlfw_pkg;

	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 16;
	localparam int FEAT_BITS     = 4;
	localparam int WIN_BITS      = 16;
	localparam int FIELD_BITS    = 32;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FEATURES  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FAIL_WIN  = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN  = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLEAR_GAP = 4'd3;

	localparam logic [WIN_BITS-1:0] FAIL_WIN_RST  = 16'd3000;
	localparam logic [WIN_BITS-1:0] COOLDOWN_RST  = 16'd20000;
	localparam logic [WIN_BITS-1:0] CLEAR_GAP_RST = 16'd750;

	// feature bit positions
	localparam int FEAT_DISPLAY = 0;
	localparam int FEAT_CAN     = 1;
	localparam int FEAT_KLINE   = 2;
	localparam int FEAT_OVERLAY = 3;

	typedef struct packed {
		logic boot_ready;
		logic ignition_on;
		logic display_disabled;
		logic menu_open;
		logic can_connected;
		logic kline_connected;
		logic overlay_shown;
	} link_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/display_link_failure_watchdog.sv
// display link failure watchdog: error streak tracking and restart request
//
// Usage: one request on the input channel per render cycle, carrying the
// millisecond timestamp, the running transfer-error count and the link status
// bits. Each request yields exactly one result on the output channel:
// restart_request (one result wide pulse), streak_active and cycle_errored.
// An accepted request passes through one input register; the streak logic then
// writes the result register and the watchdog state in the same cycle.
// Throughput is one request per clock while results are taken; the limit is the
// single state update per request (three wrapping subtracts and compares).
// The configuration channel (cfg_index, cfg_data) is always ready; write only
// while no request is in flight. Unknown indexes are dropped.
// Reset clears the streak state, the error count history and loads the
// default fail window, cooldown and clear gap; no display card is fitted.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready then drops until the result is taken.
`default_nettype none
`include "display_link_failure_watchdog_assert.svh"
module display_link_failure_watchdog #(
	parameter int TIME_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [dlfw_pkg::FIELD_BITS-1:0] now_ms,
	input  wire logic [dlfw_pkg::FIELD_BITS-1:0] error_count,
	input  wire logic boot_ready,
	input  wire logic ignition_on,
	input  wire logic display_disabled,
	input  wire logic menu_open,
	input  wire logic can_connected,
	input  wire logic kline_connected,
	input  wire logic overlay_shown,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      restart_request,
	output logic      streak_active,
	output logic      cycle_errored,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [dlfw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [dlfw_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// configuration
	logic [dlfw_pkg::FEAT_BITS-1:0] features_q;
	logic [dlfw_pkg::WIN_BITS-1:0]  fail_win_q;
	logic [dlfw_pkg::WIN_BITS-1:0]  cooldown_q;
	logic [dlfw_pkg::WIN_BITS-1:0]  clear_gap_q;

	// input stage
	logic                            valid_s1;
	logic [TIME_BITS-1:0]            now_s1;
	logic [dlfw_pkg::FIELD_BITS-1:0] errs_s1;
	dlfw_pkg::link_status_t          link_s1;

	// watchdog state
	logic [dlfw_pkg::FIELD_BITS-1:0] prev_errs_q;
	logic                            streak_q;
	logic [TIME_BITS-1:0]            streak_start_q;
	logic [TIME_BITS-1:0]            last_err_q;
	logic [TIME_BITS-1:0]            last_restart_q;

	// result register
	logic out_valid_q;
	logic restart_q;
	logic active_q;
	logic errored_q;

	logic                 adv;
	logic                 errored;
	logic                 src_ok;
	logic                 expecting;
	logic [TIME_BITS-1:0] since_start;
	logic [TIME_BITS-1:0] since_err;
	logic [TIME_BITS-1:0] since_restart;
	logic                 win_done;
	logic                 cool_done;
	logic                 gap_done;
	logic                 restart_nx;
	logic                 streak_nx;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	assign out_valid       = out_valid_q;
	assign restart_request = restart_q;
	assign streak_active   = active_q;
	assign cycle_errored   = errored_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			features_q  <= '0;
			fail_win_q  <= dlfw_pkg::FAIL_WIN_RST;
			cooldown_q  <= dlfw_pkg::COOLDOWN_RST;
			clear_gap_q <= dlfw_pkg::CLEAR_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dlfw_pkg::CFG_FEATURES:  features_q  <= cfg_data[dlfw_pkg::FEAT_BITS-1:0];
				dlfw_pkg::CFG_FAIL_WIN:  fail_win_q  <= cfg_data;
				dlfw_pkg::CFG_COOLDOWN:  cooldown_q  <= cfg_data;
				dlfw_pkg::CFG_CLEAR_GAP: clear_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			// time base is truncated or zero-extended to the counter width
			now_s1  <= TIME_BITS'(now_ms);
			errs_s1 <= error_count;
			link_s1 <= '{boot_ready, ignition_on, display_disabled, menu_open,
				can_connected, kline_connected, overlay_shown};
		end
	end

	assign errored = errs_s1 != prev_errs_q;

	assign src_ok = (features_q[dlfw_pkg::FEAT_CAN] && link_s1.can_connected) ||
		(features_q[dlfw_pkg::FEAT_KLINE] && link_s1.kline_connected) ||
		(features_q[dlfw_pkg::FEAT_OVERLAY] && link_s1.overlay_shown);
	assign expecting = features_q[dlfw_pkg::FEAT_DISPLAY] && link_s1.boot_ready &&
		link_s1.ignition_on && !link_s1.display_disabled && !link_s1.menu_open && src_ok;

	// wrapping differences
	assign since_start   = now_s1 - streak_start_q;
	assign since_err     = now_s1 - last_err_q;
	assign since_restart = now_s1 - last_restart_q;

	assign win_done  = since_start >= TIME_BITS'(fail_win_q);
	assign cool_done = since_restart >= TIME_BITS'(cooldown_q);
	assign gap_done  = since_err >= TIME_BITS'(clear_gap_q);

	always_comb begin
		restart_nx = 1'b0;
		streak_nx  = streak_q;
		if (!expecting) begin
			streak_nx = 1'b0;
		end else if (errored) begin
			if (!streak_q) begin
				streak_nx = 1'b1;
			end else if (win_done && cool_done) begin
				restart_nx = 1'b1;
				streak_nx  = 1'b0;
			end
		end else if (streak_q && gap_done) begin
			streak_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_errs_q    <= '0;
			streak_q       <= 1'b0;
			streak_start_q <= '0;
			last_err_q     <= '0;
			last_restart_q <= '0;
		end else if (adv) begin
			prev_errs_q <= errs_s1;
			streak_q    <= streak_nx;
			if (expecting && errored) begin
				last_err_q <= now_s1;
				if (!streak_q) begin
					streak_start_q <= now_s1;
				end
			end
			if (restart_nx) begin
				last_restart_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			restart_q <= restart_nx;
			active_q  <= streak_nx;
			errored_q <= errored;
		end
	end

	// a restart always ends the streak and comes from an errored cycle
	`DLFW_ASSERT_NOW(a_restart_ends_streak, clk, arst_n, out_valid_q && restart_q, !active_q && errored_q)
	// a stalled input stage keeps its request
	`DLFW_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv, valid_s1)
	// restart time only moves together with a restart result
	`DLFW_ASSERT_NOW(a_restart_time, clk, arst_n, !$stable(last_restart_q), out_valid_q && restart_q)
	// streak state mirrors the last result
	`DLFW_ASSERT_NOW(a_streak_mirror, clk, arst_n, out_valid_q, active_q == streak_q)

endmodule
`default_nettype wire

FILE: bench/display_link_failure_watchdog_tb.sv
// self-checking bench for the display link failure watchdog: shadow model, random traffic
`timescale 1ns / 1ps
module display_link_failure_watchdog_tb;

	localparam int STALL_LIMIT = 2000;
	localparam logic [dlfw_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 4'd9;

	localparam dlfw_pkg::link_status_t LINK_GOOD = '{
		boot_ready: 1'b1, ignition_on: 1'b1, display_disabled: 1'b0, menu_open: 1'b0,
		can_connected: 1'b1, kline_connected: 1'b1, overlay_shown: 1'b1
	};

	typedef struct packed {
		logic [dlfw_pkg::FIELD_BITS-1:0] now;
		logic [dlfw_pkg::FIELD_BITS-1:0] errs;
		dlfw_pkg::link_status_t          st;
	} render_req_t;

	typedef struct packed {
		logic restart;
		logic streak;
		logic errored;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [dlfw_pkg::FIELD_BITS-1:0] now_ms = '0;
	logic [dlfw_pkg::FIELD_BITS-1:0] error_count = '0;
	logic                            boot_ready = 1'b0;
	logic                            ignition_on = 1'b0;
	logic                            display_disabled = 1'b0;
	logic                            menu_open = 1'b0;
	logic                            can_connected = 1'b0;
	logic                            kline_connected = 1'b0;
	logic                            overlay_shown = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            restart_request;
	logic                            streak_active;
	logic                            cycle_errored;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dlfw_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [dlfw_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	// shadow of the watchdog registers and state
	logic [dlfw_pkg::FEAT_BITS-1:0]  feat_sh = '0;
	logic [dlfw_pkg::WIN_BITS-1:0]   fail_win_sh = dlfw_pkg::FAIL_WIN_RST;
	logic [dlfw_pkg::WIN_BITS-1:0]   cooldown_sh = dlfw_pkg::COOLDOWN_RST;
	logic [dlfw_pkg::WIN_BITS-1:0]   clear_gap_sh = dlfw_pkg::CLEAR_GAP_RST;
	logic [dlfw_pkg::FIELD_BITS-1:0] seen_errs = '0;
	logic                            in_streak = 1'b0;
	logic [dlfw_pkg::FIELD_BITS-1:0] streak_t0 = '0;
	logic [dlfw_pkg::FIELD_BITS-1:0] last_err_t = '0;
	logic [dlfw_pkg::FIELD_BITS-1:0] last_restart_t = '0;

	render_req_t pending_reqs[$];
	verdict_t    verdicts_due[$];
	render_req_t cur_req = '0;
	render_req_t nxt;
	verdict_t    want;
	logic [dlfw_pkg::FIELD_BITS-1:0] err_tally = '0;
	bit steady = 1'b0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	display_link_failure_watchdog uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_ms(now_ms), .error_count(error_count),
		.boot_ready(boot_ready), .ignition_on(ignition_on),
		.display_disabled(display_disabled), .menu_open(menu_open),
		.can_connected(can_connected), .kline_connected(kline_connected),
		.overlay_shown(overlay_shown),
		.out_valid(out_valid), .out_ready(out_ready),
		.restart_request(restart_request), .streak_active(streak_active),
		.cycle_errored(cycle_errored),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [dlfw_pkg::FIELD_BITS-1:0] ms_since(
			input logic [dlfw_pkg::FIELD_BITS-1:0] t_now,
			input logic [dlfw_pkg::FIELD_BITS-1:0] t_then);
		return t_now - t_then;
	endfunction

	function automatic verdict_t next_verdict(input render_req_t r);
		verdict_t v;
		logic src_ok;
		logic card;
		v = '0;
		v.errored = (r.errs != seen_errs);
		seen_errs = r.errs;
		src_ok = (feat_sh[dlfw_pkg::FEAT_CAN] && r.st.can_connected) ||
			(feat_sh[dlfw_pkg::FEAT_KLINE] && r.st.kline_connected) ||
			(feat_sh[dlfw_pkg::FEAT_OVERLAY] && r.st.overlay_shown);
		card = feat_sh[dlfw_pkg::FEAT_DISPLAY] && r.st.boot_ready && r.st.ignition_on &&
			!r.st.display_disabled && !r.st.menu_open && src_ok;
		if (!card) begin
			in_streak = 1'b0;
		end else if (v.errored) begin
			last_err_t = r.now;
			if (!in_streak) begin
				in_streak = 1'b1;
				streak_t0 = r.now;
			end else if (ms_since(r.now, streak_t0) >= fail_win_sh &&
					ms_since(r.now, last_restart_t) >= cooldown_sh) begin
				last_restart_t = r.now;
				in_streak = 1'b0;
				v.restart = 1'b1;
			end
		end else if (in_streak && ms_since(r.now, last_err_t) >= clear_gap_sh) begin
			in_streak = 1'b0;
		end
		v.streak = in_streak;
		return v;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 37);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				verdicts_due.push_back(next_verdict(cur_req));
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && !take_break()) begin
					nxt = pending_reqs.pop_front();
					cur_req <= nxt;
					now_ms <= nxt.now;
					error_count <= nxt.errs;
					boot_ready <= nxt.st.boot_ready;
					ignition_on <= nxt.st.ignition_on;
					display_disabled <= nxt.st.display_disabled;
					menu_open <= nxt.st.menu_open;
					can_connected <= nxt.st.can_connected;
					kline_connected <= nxt.st.kline_connected;
					overlay_shown <= nxt.st.overlay_shown;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = verdicts_due.pop_front();
					results_seen++;
					if (restart_request !== want.restart) begin
						$error("restart_request: expected %0b, got %0b", want.restart,
							restart_request);
						mismatches++;
					end
					if (streak_active !== want.streak) begin
						$error("streak_active: expected %0b, got %0b", want.streak,
							streak_active);
						mismatches++;
					end
					if (cycle_errored !== want.errored) begin
						$error("cycle_errored: expected %0b, got %0b", want.errored,
							cycle_errored);
						mismatches++;
					end
				end
			end
			out_ready <= !take_break();
		end
	end

	// stall watchdog
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("display_link_failure_watchdog_tb: done, errors");
		$finish;
	end

	task automatic write_reg(input logic [dlfw_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [dlfw_pkg::CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			dlfw_pkg::CFG_FEATURES:  feat_sh = val[dlfw_pkg::FEAT_BITS-1:0];
			dlfw_pkg::CFG_FAIL_WIN:  fail_win_sh = val;
			dlfw_pkg::CFG_COOLDOWN:  cooldown_sh = val;
			dlfw_pkg::CFG_CLEAR_GAP: clear_gap_sh = val;
			default: ;
		endcase
	endtask

	task automatic push_req(input logic [dlfw_pkg::FIELD_BITS-1:0] t,
			input logic [dlfw_pkg::FIELD_BITS-1:0] errs,
			input dlfw_pkg::link_status_t st);
		render_req_t r;
		r.now = t;
		r.errs = errs;
		r.st = st;
		pending_reqs.push_back(r);
		items_sent++;
	endtask

	// wait for every request to come back, then let the pipeline drain
	task automatic settle();
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [dlfw_pkg::FEAT_BITS-1:0] feat,
			input logic [dlfw_pkg::WIN_BITS-1:0] fail,
			input logic [dlfw_pkg::WIN_BITS-1:0] cool,
			input logic [dlfw_pkg::WIN_BITS-1:0] gap,
			input logic [dlfw_pkg::FIELD_BITS-1:0] base, input int step_max, input int count,
			input bit quiet);
		logic [dlfw_pkg::FIELD_BITS-1:0] wall;
		logic [dlfw_pkg::FIELD_BITS-1:0] t;
		dlfw_pkg::link_status_t st;
		int roll;
		settle();
		steady = quiet;
		write_reg(dlfw_pkg::CFG_FEATURES, dlfw_pkg::CFG_DATA_BITS'(feat));
		write_reg(dlfw_pkg::CFG_FAIL_WIN, fail);
		write_reg(dlfw_pkg::CFG_COOLDOWN, cool);
		write_reg(dlfw_pkg::CFG_CLEAR_GAP, gap);
		wall = base;
		for (int i = 0; i < count; i++) begin
			wall = wall + dlfw_pkg::FIELD_BITS'($urandom_range(0, step_max));
			roll = $urandom_range(0, 99);
			if (roll < 55)
				err_tally = err_tally + dlfw_pkg::FIELD_BITS'($urandom_range(1, 3));
			else if (roll < 60)
				err_tally = $urandom;
			st = LINK_GOOD;
			st.can_connected = ($urandom_range(0, 3) != 0);
			st.kline_connected = ($urandom_range(0, 3) != 0);
			st.overlay_shown = ($urandom_range(0, 3) != 0);
			roll = $urandom_range(0, 99);
			if (roll < 8)
				st = dlfw_pkg::link_status_t'($urandom_range(0, 127));
			else if (roll < 14)
				st = dlfw_pkg::link_status_t'(st ^ (7'd1 << $urandom_range(0, 6)));
			// occasional jump in time, off the running clock
			t = ($urandom_range(0, 99) < 5) ? dlfw_pkg::FIELD_BITS'($urandom) : wall;
			push_req(t, err_tally, st);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// no card fitted after reset, count still tracked
		err_tally = 32'd1;
		push_req(32'd0, err_tally, LINK_GOOD);
		settle();
		write_reg(dlfw_pkg::CFG_FEATURES, 16'hFFFF);
		// streak opening at time zero
		push_req(32'd0, 32'd2, LINK_GOOD);
		push_req(32'd500, 32'd2, LINK_GOOD);
		push_req(32'd3000, 32'd3, LINK_GOOD);
		push_req(32'd3749, 32'd3, LINK_GOOD);
		push_req(32'd3750, 32'd3, LINK_GOOD);
		push_req(32'd4000, 32'd4, LINK_GOOD);
		// first restart, cooldown counted from zero
		push_req(32'd20000, 32'd5, LINK_GOOD);
		push_req(32'd20001, 32'd6, LINK_GOOD);
		push_req(32'd20002, 32'd7, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1});
		push_req(32'd20003, 32'd8, LINK_GOOD);
		push_req(32'd20004, 32'd9, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1});
		push_req(32'd20005, 32'd10, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
		push_req(32'd20006, 32'd11, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
		push_req(32'd20007, 32'd12, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
		push_req(32'd20008, 32'd13, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
		push_req(32'd20009, 32'd14, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
		push_req(32'd20010, 32'd15, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
		// timestamps across the wrap
		push_req(32'hFFFF_FFF0, 32'hFFFF_FFFF, LINK_GOOD);
		push_req(32'h0000_0100, 32'd0, LINK_GOOD);
		push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, dlfw_pkg::link_status_t'(7'h7F));
		push_req(32'd0, 32'd0, dlfw_pkg::link_status_t'(7'h00));
		settle();
		// write to an unused index must change nothing
		write_reg(CFG_SPARE, 16'hFFFF);
		err_tally = '0;

		run_phase(4'hF, 16'd1, 16'd0, 16'd0, 32'hFFFF_FFF0, 3, 100, 1'b0);
		run_phase(4'h3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_0000, 4000, 100, 1'b0);
		run_phase(4'h5, 16'd0, 16'd10, 16'd5, 32'd0, 4, 100, 1'b1);
		run_phase(4'h9, 16'd40, 16'd100, 16'd25, $urandom, 8, 100, 1'b0);
		for (int p = 0; p < 3; p++)
			run_phase(dlfw_pkg::FEAT_BITS'($urandom_range(0, 15) | 1),
				dlfw_pkg::WIN_BITS'($urandom_range(1, 300)),
				dlfw_pkg::WIN_BITS'($urandom_range(0, 600)),
				dlfw_pkg::WIN_BITS'($urandom_range(0, 100)),
				$urandom, $urandom_range(1, 20), 100, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			$error("%0d results never arrived", verdicts_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("display_link_failure_watchdog_tb: done, clean");
		else
			$display("display_link_failure_watchdog_tb: done, errors");
		$finish;
	end

endmodule
